/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRIO_W = 8;
    localparam int REGN_W = 31;
    localparam int AGE_W  = 7;
    localparam int PHON_W = 31;
    localparam int FILL_W = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [REGN_W-1:0] regno;
        logic [AGE_W-1:0]  age;
        logic [PHON_W-1:0] phone;
    } record_t;

    typedef struct packed {
        action_t           action;
        logic [PRIO_W-1:0] prio_in;
        logic [REGN_W-1:0] reg_in;
        logic [AGE_W-1:0]  age_in;
        logic [PHON_W-1:0] phone_in;
    } spq_in_t;

    typedef struct packed {
        status_t           status;
        logic [PRIO_W-1:0] prio_out;
        logic [REGN_W-1:0] reg_out;
        logic [AGE_W-1:0]  age_out;
        logic [PHON_W-1:0] phone_out;
        logic [FILL_W-1:0] fill;
    } spq_out_t;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: command decode, fill count and the cell chain.
//
// Usage:
//   Drive cmd and raise start for one cycle to issue a command; a transfer
//   happens at the rising edge where start is high and busy is low.
//   action insert places the record behind every held record of lower or
//   equal priority, so ties leave in arrival order; action remove pops the
//   head (lowest priority value) and returns it on result.
//   Each command yields exactly one result: done is high for one cycle, the
//   cycle right after the command transfer, and result holds status, the
//   removed record (zero unless removed) and the fill after the command.
//   Throughput is one command per cycle. The records live in a chain of
//   DEPTH cells that all compare against the broadcast priority and shift
//   together, so each command updates the whole chain at the edge that takes it.
//   busy is held low: the block takes a command in every cycle.
//   The receiver cannot stall; a result is seen for exactly one cycle.
//   Reset (rst_n low, asynchronous) empties the queue and drops done;
//   the record slots keep stale data, which is never read past the fill.
//   An insert on a full queue reports full and drops the record; a remove
//   on an empty queue reports empty. Neither changes the contents.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire spq_pkg::spq_in_t cmd,
    output logic                  done,
    output spq_pkg::spq_out_t     result
);
    import spq_pkg::*;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             done_reg;
    logic             done_next;
    spq_out_t         result_reg;
    spq_out_t         result_next;

    logic             accept;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    record_t          new_rec;

    record_t          cell_rec   [DEPTH];
    logic             cell_gt    [DEPTH];
    logic             cell_valid [DEPTH];

    // Every command completes at the edge that takes it, so never hold off start.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (occ_reg == CNT_W'(DEPTH));
    assign empty  = (occ_reg == '0);

    assign new_rec.prio  = cmd.prio_in;
    assign new_rec.regno = cmd.reg_in;
    assign new_rec.age   = cmd.age_in;
    assign new_rec.phone = cmd.phone_in;

    // Gate the broadcast so rejected commands leave the chain untouched.
    assign ctl.insert = accept && (cmd.action == ACT_INSERT) && !full;
    assign ctl.remove = accept && (cmd.action == ACT_REMOVE) && !empty;

    // Build the chain. A slot is live while its index is below the fill count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic    left_gt;
        record_t left_rec;
        record_t right_rec;

        assign cell_valid[i] = (occ_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_gt  = 1'b0;
            assign left_rec = new_rec;
        end
        else
        begin : g_body
            assign left_gt  = cell_gt[i-1];
            assign left_rec = cell_rec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_rec = cell_rec[i];
        end
        else
        begin : g_inner
            assign right_rec = cell_rec[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .new_rec   (new_rec),
            .valid     (cell_valid[i]),
            .left_gt   (left_gt),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .gt        (cell_gt[i]),
            .rec       (cell_rec[i])
        );
    end

    // Decode the result and the next fill count.
    always_comb
    begin
        occ_next    = occ_reg;
        done_next   = accept;
        result_next = '0;

        if (ctl.insert)
            occ_next = occ_reg + CNT_W'(1);
        else if (ctl.remove)
            occ_next = occ_reg - CNT_W'(1);

        case (cmd.action)
            ACT_INSERT:
            begin
                result_next.status = full ? ST_FULL : ST_INSERTED;
            end
            ACT_REMOVE:
            begin
                if (empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    result_next.status    = ST_REMOVED;
                    result_next.prio_out  = cell_rec[0].prio;
                    result_next.reg_out   = cell_rec[0].regno;
                    result_next.age_out   = cell_rec[0].age;
                    result_next.phone_out = cell_rec[0].phone;
                end
            end
            default:
            begin
                result_next.status = ST_EMPTY;
            end
        endcase

        result_next.fill = FILL_W'(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            done_reg <= done_next;
        end
    end

    // Hold the result payload; only its strobe needs a reset.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds a record, shifts right on insert, left on remove.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                  clk,
    input  wire spq_pkg::cell_ctl_t    ctl,
    input  wire spq_pkg::record_t      new_rec,
    input  wire logic                  valid,
    input  wire logic                  left_gt,
    input  wire spq_pkg::record_t      left_rec,
    input  wire spq_pkg::record_t      right_rec,
    output logic                       gt,
    output spq_pkg::record_t           rec
);
    import spq_pkg::*;

    record_t rec_reg;
    record_t rec_next;

    // An empty slot counts as "after" the new record.
    assign gt  = !valid || (rec_reg.prio > new_rec.prio);
    assign rec = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.insert)
        begin
            if (left_gt)
                rec_next = left_rec;
            else if (gt)
                rec_next = new_rec;
        end
        else if (ctl.remove)
        begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire spq_pkg::spq_out_t result
);
    import spq_pkg::*;

    // Every transfer yields a result in the next cycle.
    a_cmd_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command transfer without a result");

    // No result appears without a command before it.
    a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a command");

    // Only a removal carries a record.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_REMOVED)) |->
            (result.prio_out == '0 && result.reg_out == '0 &&
             result.age_out == '0 && result.phone_out == '0))
        else $error("record fields set without a removal");

    // Empty and full reports agree with the fill count.
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_EMPTY)) |-> (result.fill == '0))
        else $error("empty report with records held");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.fill == FILL_W'(DEPTH)))
        else $error("full report below capacity");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

/* tb/sv/sorted_priority_queue_tb.sv */
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    import spq_pkg::*;

    // Give up when a correct run could never take this long. The slowest
    // correct run is 985 commands, many of them behind random sender idling.
    localparam int CYCLE_LIMIT = 300000;
    // Let this many cycles pass after the last result before ending.
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS = 25;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 120;

    localparam logic [REGN_W-1:0] REGN_MAX = '1;
    localparam logic [AGE_W-1:0]  AGE_MAX  = '1;
    localparam logic [PHON_W-1:0] PHON_MAX = '1;

    // One row of the directed table. Where the expected result is obvious
    // it is typed in, otherwise the queue model supplies it.
    typedef struct {
        spq_in_t  cmd;
        bit       typed;
        spq_out_t want;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    spq_in_t  cmd = '0;
    logic     busy;
    logic     done;
    spq_out_t result;

    // Typed expectation that travels with the command being offered.
    bit       row_typed = 1'b0;
    spq_out_t row_want = '0;

    // Model of the queue contents, head first, and results still owed.
    record_t  held_records[$];
    spq_out_t owed_results[$];

    int n_transfers = 0;
    int n_errors = 0;
    int n_cycles = 0;

    // Per-phase sender idling, insert bias and priority span. Narrow spans
    // force ties; strong insert bias fills the queue, weak bias drains it.
    int phase_idle [N_PHASES] = '{0, 74, 34, 0, 74, 34, 0, 20};
    int phase_ins  [N_PHASES] = '{50, 85, 15, 60, 90, 10, 50, 55};
    int phase_span [N_PHASES] = '{255, 3, 255, 15, 255, 255, 7, 255};

    sorted_priority_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the queue model and return the result it owes.
    // Insert goes behind every held record of lower or equal priority, so
    // ties leave in arrival order; remove pops the head.
    function automatic spq_out_t queue_apply(spq_in_t c);
        spq_out_t r;
        record_t  rec;
        int       pos;
        r = '0;
        if (c.action == ACT_INSERT) begin
            if (held_records.size() >= DEPTH) begin
                // Full: drop the record, contents untouched.
                r.status = ST_FULL;
            end
            else begin
                rec.prio  = c.prio_in;
                rec.regno = c.reg_in;
                rec.age   = c.age_in;
                rec.phone = c.phone_in;
                pos = 0;
                while (pos < held_records.size() && held_records[pos].prio <= c.prio_in)
                    pos++;
                held_records.insert(pos, rec);
                r.status = ST_INSERTED;
            end
        end
        else if (held_records.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            rec = held_records.pop_front();
            r.status    = ST_REMOVED;
            r.prio_out  = rec.prio;
            r.reg_out   = rec.regno;
            r.age_out   = rec.age;
            r.phone_out = rec.phone;
        end
        r.fill = FILL_W'(held_records.size());
        return r;
    endfunction

    function automatic spq_in_t mk_cmd(action_t a, logic [PRIO_W-1:0] p,
                                       logic [REGN_W-1:0] rn, logic [AGE_W-1:0] ag,
                                       logic [PHON_W-1:0] ph);
        spq_in_t c;
        c.action   = a;
        c.prio_in  = p;
        c.reg_in   = rn;
        c.age_in   = ag;
        c.phone_in = ph;
        return c;
    endfunction

    function automatic spq_out_t mk_res(status_t s, logic [PRIO_W-1:0] p,
                                        logic [REGN_W-1:0] rn, logic [AGE_W-1:0] ag,
                                        logic [PHON_W-1:0] ph, logic [FILL_W-1:0] f);
        spq_out_t r;
        r.status    = s;
        r.prio_out  = p;
        r.reg_out   = rn;
        r.age_out   = ag;
        r.phone_out = ph;
        r.fill      = f;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Sample at the rising edge: first match a result against the oldest
    // owed one, then log a command transfer and predict its result. The
    // result of a transfer is registered and shows up at the next edge, so the order is safe.
    always @(posedge clk)
    begin : monitor
        spq_out_t want;
        if (rst_n) begin
            if (done === 1'b1) begin
                if (owed_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, actual %0h",
                             $time, result);
                    n_errors++;
                end
                else begin
                    want = owed_results.pop_front();
                    check_field("status",    32'(want.status),    32'(result.status));
                    check_field("prio_out",  32'(want.prio_out),  32'(result.prio_out));
                    check_field("reg_out",   32'(want.reg_out),   32'(result.reg_out));
                    check_field("age_out",   32'(want.age_out),   32'(result.age_out));
                    check_field("phone_out", 32'(want.phone_out), 32'(result.phone_out));
                    check_field("fill",      32'(want.fill),      32'(result.fill));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                // Always advance the model; a typed row overrides its answer.
                want = queue_apply(cmd);
                if (row_typed)
                    want = row_want;
                owed_results.push_back(want);
                n_transfers++;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one command. Called at a falling edge; idle the sender at random
    // first, then hold start high until the monitor logs the transfer, and
    // return at the falling edge right after it.
    task automatic send_cmd(spq_in_t c, bit typed, spq_out_t want, int idle_pct);
        int seen;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        cmd       <= c;
        row_typed <= typed;
        row_want  <= want;
        seen = n_transfers;
        do
            @(negedge clk);
        while (n_transfers == seen);
    endtask

    initial
    begin : stimulus
        dir_row_t dir_rows [DIR_ROWS];
        spq_in_t  c;
        int       ph;
        int       k;

        dir_rows = '{
            // Remove on an empty queue straight after reset.
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b1,
              mk_res(ST_EMPTY, '0, '0, '0, '0, 5'd0)},
            // All-ones record in and back out.
            '{mk_cmd(ACT_INSERT, 8'd255, REGN_MAX, AGE_MAX, PHON_MAX), 1'b1,
              mk_res(ST_INSERTED, '0, '0, '0, '0, 5'd1)},
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b1,
              mk_res(ST_REMOVED, 8'd255, REGN_MAX, AGE_MAX, PHON_MAX, 5'd0)},
            '{mk_cmd(ACT_REMOVE, 8'd9, REGN_MAX, AGE_MAX, PHON_MAX), 1'b1,
              mk_res(ST_EMPTY, '0, '0, '0, '0, 5'd0)},
            // All-zero record first, then fill to the brim with ties mixed in.
            '{mk_cmd(ACT_INSERT, 8'd0, '0, '0, '0), 1'b1,
              mk_res(ST_INSERTED, '0, '0, '0, '0, 5'd1)},
            '{mk_cmd(ACT_INSERT, 8'd0, 31'h5555_5555, 7'h55, 31'h2AAA_AAAA), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd255, 31'h2AAA_AAAA, 7'h2A, 31'h5555_5555), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd128, 31'd1, 7'd1, 31'd1), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd128, 31'd2, 7'd2, 31'd2), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd1, 31'h4000_0000, 7'h40, 31'h4000_0000), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd254, 31'd3, 7'd3, 31'd3), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd7, 31'd4, 7'd4, 31'd4), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd7, 31'd5, 7'd5, 31'd5), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd7, 31'd6, 7'd6, 31'd6), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd64, 31'h1234_5678, 7'h12, 31'h7654_3210), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd200, 31'd7, 7'd7, 31'd7), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd3, 31'd8, 7'd8, 31'd8), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd100, 31'd9, 7'd9, 31'd9), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd0, 31'd10, 7'd10, 31'd10), 1'b0, '0},
            '{mk_cmd(ACT_INSERT, 8'd127, REGN_MAX, 7'd0, PHON_MAX), 1'b0, '0},
            // Insert on a full queue: dropped, fill stays at the top.
            '{mk_cmd(ACT_INSERT, 8'd0, REGN_MAX, AGE_MAX, PHON_MAX), 1'b1,
              mk_res(ST_FULL, '0, '0, '0, '0, 5'(DEPTH))},
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b0, '0},
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b0, '0},
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b0, '0},
            '{mk_cmd(ACT_REMOVE, 8'd0, '0, '0, '0), 1'b0, '0}
        };

        // Hold reset, then release it at a falling edge, away from the rising edge.
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, back to back.
        for (k = 0; k < DIR_ROWS; k++)
            send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want, 0);

        // Random part: phases differ in sender idling, insert bias and the
        // spread of priorities, so the queue sweeps between empty and full.
        for (ph = 0; ph < N_PHASES; ph++) begin
            for (k = 0; k < PHASE_ITEMS; k++) begin
                c.action   = ($urandom_range(0, 99) < phase_ins[ph]) ? ACT_INSERT : ACT_REMOVE;
                c.prio_in  = PRIO_W'($urandom_range(0, phase_span[ph]));
                c.reg_in   = REGN_W'($urandom);
                c.age_in   = AGE_W'($urandom);
                c.phone_in = PHON_W'($urandom);
                send_cmd(c, 1'b0, '0, phase_idle[ph]);
            end
        end
        start     <= 1'b0;
        row_typed <= 1'b0;

        // Drain: wait for every owed result, then a few more cycles to catch
        // any stray result. The watchdog bounds this wait.
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
